FILE: src/vn_pkg.sv
// Shared constants and types for the 3D vector normalizer.
// No dependencies; every other file in src refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package vn_pkg;

   localparam int IN_WIDTH_DEF      = 16;
   localparam int OUT_FRAC_BITS_DEF = 15;
   localparam int UNIT_WIDTH        = 16;
   localparam int NUM_LANES         = 3;
   localparam int RSP_DATA_WIDTH    = NUM_LANES * UNIT_WIDTH;

   // Per-cycle strobes from the sequencer to the lanes and the merging stage.
   typedef struct packed {
      logic load;
      logic square;
      logic sum;
      logic init;
      logic step;
   } lane_ctrl_type;

endpackage

`default_nettype wire

FILE: src/vec3_normalizer.sv
// Top level of the 3D vector normalizer: sequencer, three component lanes,
// the merging stage and the result register. Depends on vn_pkg, vn_lane, vn_sum.
//
//   channel   direction  tdata (low bit up)              tuser
//   req_*     in         comp_x, comp_y, comp_z          -
//   rsp_*     out        unit_x, unit_y, unit_z          was_zero
//
// An item passes from acceptance to the result register through magnitude,
// squaring, the lane sum and the first quotient bit, then OUT_FRAC_BITS + 1
// square-root steps, which set the rate. Only one item is in flight; the next
// is accepted once the result is registered, even while rsp_tvalid waits on
// rsp_tready.
// Reset is synchronous and clears the sequencer and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none

module vec3_normalizer #(
   parameter int IN_WIDTH      = vn_pkg::IN_WIDTH_DEF,
   parameter int OUT_FRAC_BITS = vn_pkg::OUT_FRAC_BITS_DEF
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_tvalid,
   output logic                                    req_tready,
   // comp_x, comp_y, comp_z, zero fill to whole bytes
   input  wire  logic [((3*IN_WIDTH+7)/8)*8-1:0]   req_tdata,
   output logic                                    rsp_tvalid,
   input  wire                                     rsp_tready,
   // unit_x, unit_y, unit_z
   output logic [vn_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata,
   // was_zero
   output logic                                    rsp_tuser
);

   localparam int F     = OUT_FRAC_BITS;
   localparam int UW    = vn_pkg::UNIT_WIDTH;
   localparam int LANES = vn_pkg::NUM_LANES;
   localparam int CNT_W = $clog2(F + 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SQUARE = 6'b000010,
      ST_SUM    = 6'b000100,
      ST_INIT   = 6'b001000,
      ST_RUN    = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff,   cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [LANES*UW-1:0]         rsp_data_ff,  rsp_data_in;
   logic                        rsp_zero_ff,  rsp_zero_in;

   vn_pkg::lane_ctrl_type       ctrl;
   logic [2*IN_WIDTH-2:0]       square [LANES];
   logic [UW-1:0]               unit   [LANES];
   logic [2*IN_WIDTH-1:0]       sum;
   logic                        is_zero;
   logic                        req_accept;
   logic                        rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign ctrl.load   = req_accept;
   assign ctrl.square = (state_ff == ST_SQUARE);
   assign ctrl.sum    = (state_ff == ST_SUM);
   assign ctrl.init   = (state_ff == ST_INIT);
   assign ctrl.step   = (state_ff == ST_RUN);

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      vn_lane #(
         .IN_WIDTH      (IN_WIDTH),
         .OUT_FRAC_BITS (OUT_FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .ctrl   (ctrl),
         .comp   (req_tdata[i*IN_WIDTH +: IN_WIDTH]),
         .sum    (sum),
         .square (square[i]),
         .unit   (unit[i])
      );
   end

   vn_sum #(
      .IN_WIDTH (IN_WIDTH)
   ) u_sum (
      .clock   (clock),
      .ctrl    (ctrl),
      .square  (square),
      .sum     (sum),
      .is_zero (is_zero)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_zero_in  = rsp_zero_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cnt_in   = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(F)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_zero_in  = is_zero;
               for (int i = 0; i < LANES; i++) begin
                  rsp_data_in[i*UW +: UW] = is_zero ? '0 : unit[i];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_zero_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   a_step_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (cnt_ff <= CNT_W'(F)))
      else $error("square-root step count ran past the last step");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("zero vector produced a nonzero unit vector");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (rsp_tvalid && state_ff == ST_IDLE))
      else $error("finished result was not registered");

endmodule

`default_nettype wire

FILE: src/vn_lane.sv
// One component lane: magnitude, square, then quotient m*m*2^(2F)/S two bits a
// cycle feeding a digit-by-digit square root. Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vn_lane #(
   parameter int IN_WIDTH      = vn_pkg::IN_WIDTH_DEF,
   parameter int OUT_FRAC_BITS = vn_pkg::OUT_FRAC_BITS_DEF
) (
   input  wire                                  clock,
   input  wire  vn_pkg::lane_ctrl_type          ctrl,
   input  wire  logic [IN_WIDTH-1:0]            comp,
   input  wire  logic [2*IN_WIDTH-1:0]          sum,
   output logic [2*IN_WIDTH-2:0]                square,
   output logic [vn_pkg::UNIT_WIDTH-1:0]        unit
);

   localparam int SQW = 2 * IN_WIDTH - 1;
   localparam int SW  = 2 * IN_WIDTH;
   localparam int F   = OUT_FRAC_BITS;
   localparam int UW  = vn_pkg::UNIT_WIDTH;

   logic [IN_WIDTH-1:0] mag_ff,   mag_in;
   logic                neg_ff,   neg_in;
   logic [SQW-1:0]      sq_ff,    sq_in;
   logic [SW-1:0]       rem_ff,   rem_in;
   logic [1:0]          pair_ff,  pair_in;
   logic [F:0]          root_ff,  root_in;
   logic [F+1:0]        srem_ff,  srem_in;

   logic [2*IN_WIDTH-1:0] prod;
   logic                  init_bit;
   logic [SW:0]           sum_ext;
   logic [SW:0]           div1_sh;
   logic [SW:0]           div2_sh;
   logic                  div1_ge;
   logic                  div2_ge;
   logic [SW-1:0]         div1_rem;
   logic [SW-1:0]         div2_rem;
   logic [F+3:0]          sq_sh;
   logic [F+3:0]          trial;
   logic                  sq_ge;
   logic [F+3:0]          sq_diff;
   logic [F:0]            q_sat;
   logic signed [F+1:0]   q_signed;

   assign prod     = mag_ff * mag_ff;
   assign init_bit = ({1'b0, sq_ff} >= sum);
   assign sum_ext  = {1'b0, sum};

   // Two restoring division steps per cycle; the quotient is bounded by 2^(2F).
   assign div1_sh  = {rem_ff, 1'b0};
   assign div1_ge  = (div1_sh >= sum_ext);
   assign div1_rem = div1_ge ? SW'(div1_sh - sum_ext) : div1_sh[SW-1:0];
   assign div2_sh  = {div1_rem, 1'b0};
   assign div2_ge  = (div2_sh >= sum_ext);
   assign div2_rem = div2_ge ? SW'(div2_sh - sum_ext) : div2_sh[SW-1:0];

   // Square root step on the quotient bit pair produced in the previous cycle.
   assign sq_sh   = {srem_ff, pair_ff};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign sq_ge   = (sq_sh >= trial);
   assign sq_diff = sq_sh - trial;

   always_comb begin
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      sq_in   = sq_ff;
      rem_in  = rem_ff;
      pair_in = pair_ff;
      root_in = root_ff;
      srem_in = srem_ff;
      if (ctrl.load) begin
         neg_in = comp[IN_WIDTH-1];
         mag_in = comp[IN_WIDTH-1] ? IN_WIDTH'(~comp + 1'b1) : comp;
      end
      if (ctrl.square) begin
         sq_in = prod[SQW-1:0];
      end
      if (ctrl.init) begin
         rem_in  = init_bit ? SW'({1'b0, sq_ff} - sum) : SW'(sq_ff);
         pair_in = {1'b0, init_bit};
         root_in = '0;
         srem_in = '0;
      end
      if (ctrl.step) begin
         rem_in  = div2_rem;
         pair_in = {div1_ge, div2_ge};
         root_in = {root_ff[F-1:0], sq_ge};
         srem_in = sq_ge ? sq_diff[F+1:0] : sq_sh[F+1:0];
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      sq_ff   <= sq_in;
      rem_ff  <= rem_in;
      pair_ff <= pair_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
   end

   // A component carrying the whole length gives 2^F, which saturates.
   assign q_sat    = root_ff[F] ? {1'b0, {F{1'b1}}} : root_ff;
   assign q_signed = neg_ff ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
   assign unit     = UW'(q_signed);
   assign square   = sq_ff;

endmodule

`default_nettype wire

FILE: src/vn_sum.sv
// Merging stage: adds the squared components of all lanes into the divisor and
// flags the zero vector. Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vn_sum #(
   parameter int IN_WIDTH = vn_pkg::IN_WIDTH_DEF
) (
   input  wire                          clock,
   input  wire  vn_pkg::lane_ctrl_type  ctrl,
   input  wire  logic [2*IN_WIDTH-2:0]  square [vn_pkg::NUM_LANES],
   output logic [2*IN_WIDTH-1:0]        sum,
   output logic                         is_zero
);

   localparam int SW = 2 * IN_WIDTH;

   logic [SW-1:0] sum_ff, sum_in;
   logic          zero_ff, zero_in;
   logic [SW-1:0] total;

   always_comb begin
      total = '0;
      for (int i = 0; i < vn_pkg::NUM_LANES; i++) begin
         total = total + SW'(square[i]);
      end
   end

   always_comb begin
      sum_in  = sum_ff;
      zero_in = zero_ff;
      if (ctrl.sum) begin
         sum_in  = total;
         zero_in = (total == '0);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      zero_ff <= zero_in;
   end

   assign sum     = sum_ff;
   assign is_zero = zero_ff;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for vec3_normalizer: directed and random vectors with
// random idle cycles on both streams, checked against a built-in exact predictor.
// Depends on vn_pkg and the vec3_normalizer RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int COMP_W = vn_pkg::IN_WIDTH_DEF;
   localparam int UNIT_W = vn_pkg::UNIT_WIDTH;
   localparam int FRAC_W = vn_pkg::OUT_FRAC_BITS_DEF;
   localparam int REQ_W  = ((3 * COMP_W + 7) / 8) * 8;
   localparam int RSP_W  = vn_pkg::RSP_DATA_WIDTH;
   localparam int RANDOM_VECTORS = 1400;
   localparam int DRAIN_CYCLES   = 3 * (FRAC_W + 5);

   typedef struct packed {
      logic [UNIT_W-1:0] unit_x;
      logic [UNIT_W-1:0] unit_y;
      logic [UNIT_W-1:0] unit_z;
      logic              was_zero;
   } unit_vec_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;   // comp_x, comp_y, comp_z
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;   // unit_x, unit_y, unit_z
   logic              rsp_tuser;   // was_zero

   unit_vec_type unit_vectors_due[$];
   int           mismatch_count = 0;
   bit           steady_flow    = 1'b0;

   vec3_normalizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Largest q with q*q*sum <= c*c*2^(2*FRAC_W), saturated, with the sign of c.
   function automatic logic [UNIT_W-1:0] unit_component(logic signed [COMP_W-1:0] c,
                                                        logic [63:0] sum);
      logic [COMP_W:0] mag;
      logic [127:0]    bound;
      logic [127:0]    trial;
      logic [UNIT_W:0] q;
      logic [UNIT_W:0] cand;
      mag   = (c < 0) ? (COMP_W+1)'(-int'(c)) : (COMP_W+1)'(c);
      bound = (128'(mag) * 128'(mag)) << (2 * FRAC_W);
      q     = '0;
      for (int b = FRAC_W; b >= 0; b--) begin
         cand  = q | ((UNIT_W+1)'(1) << b);
         trial = 128'(cand) * 128'(cand) * 128'(sum);
         if (trial <= bound) q = cand;
      end
      if (q > (UNIT_W+1)'((1 << FRAC_W) - 1)) q = (UNIT_W+1)'((1 << FRAC_W) - 1);
      return (c < 0) ? UNIT_W'((UNIT_W+1)'(0) - q) : UNIT_W'(q);
   endfunction

   function automatic unit_vec_type normalize_vector(logic signed [COMP_W-1:0] x,
                                                     logic signed [COMP_W-1:0] y,
                                                     logic signed [COMP_W-1:0] z);
      unit_vec_type r;
      logic [63:0]  sum;
      sum = 64'(longint'(x) * longint'(x) + longint'(y) * longint'(y)
                + longint'(z) * longint'(z));
      if (sum == 0) begin
         r = '{unit_x: '0, unit_y: '0, unit_z: '0, was_zero: 1'b1};
      end else begin
         r.unit_x   = unit_component(x, sum);
         r.unit_y   = unit_component(y, sum);
         r.unit_z   = unit_component(z, sum);
         r.was_zero = 1'b0;
      end
      return r;
   endfunction

   // Mostly back-to-back, some short pauses, now and then a long one.
   function automatic int idle_cycles();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic flag_mismatch(string what, logic [UNIT_W-1:0] got, logic [UNIT_W-1:0] want);
      $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Drives one vector and waits for its transaction; data stays valid until the
   // next call so that back-to-back vectors keep tvalid high.
   task automatic push_vector(int x, int y, int z);
      int gap;
      gap = idle_cycles();
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_W'({$urandom, $urandom});
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {COMP_W'(z), COMP_W'(y), COMP_W'(x)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      unit_vectors_due.push_back(normalize_vector(COMP_W'(x), COMP_W'(y), COMP_W'(z)));
   endtask

   always @(posedge clock) begin
      unit_vec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (unit_vectors_due.size() == 0) begin
            $display("%0t ns: result with no vector outstanding", $time);
            mismatch_count++;
         end else begin
            want = unit_vectors_due.pop_front();
            if (rsp_tdata[UNIT_W-1:0] !== want.unit_x)
               flag_mismatch("unit_x", rsp_tdata[UNIT_W-1:0], want.unit_x);
            if (rsp_tdata[2*UNIT_W-1:UNIT_W] !== want.unit_y)
               flag_mismatch("unit_y", rsp_tdata[2*UNIT_W-1:UNIT_W], want.unit_y);
            if (rsp_tdata[3*UNIT_W-1:2*UNIT_W] !== want.unit_z)
               flag_mismatch("unit_z", rsp_tdata[3*UNIT_W-1:2*UNIT_W], want.unit_z);
            if (rsp_tuser !== want.was_zero)
               flag_mismatch("was_zero", UNIT_W'(rsp_tuser), UNIT_W'(want.was_zero));
         end
      end
   end

   initial begin
      int stall;
      rsp_tready = 1'b0;
      stall      = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall = idle_cycles();
         end
      end
   end

   task automatic test_zero_vector();
      push_vector(0, 0, 0);
      push_vector(1, 0, 0);
      push_vector(0, 0, 0);
   endtask

   // A component holding the whole length saturates to +/-32767.
   task automatic test_axis_extremes();
      push_vector(32767, 0, 0);
      push_vector(-32768, 0, 0);
      push_vector(0, -32768, 0);
      push_vector(0, 32767, 0);
      push_vector(0, 0, 32767);
      push_vector(0, 0, -32767);
      push_vector(-1, 0, 0);
      push_vector(0, 0, 1);
   endtask

   task automatic test_mixed_extremes();
      push_vector(-32768, -32768, -32768);
      push_vector(32767, 32767, 32767);
      push_vector(32767, -32768, 32767);
      push_vector(1, 1, 1);
      push_vector(-1, 1, -1);
      push_vector(1, -32768, 0);
      push_vector(32767, 1, -1);
      push_vector(3, 4, 0);
      push_vector(0, -3, -4);
      push_vector(2, -1, 2);
      push_vector(-32768, 32767, 1);
   endtask

   task automatic test_random_vectors();
      int c[3];
      int k;
      int corner[6] = '{-32768, -32767, -1, 0, 1, 32767};
      for (int n = 0; n < RANDOM_VECTORS; n++) begin
         if (n % 200 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 99)) inside
            [0:49]: begin
               foreach (c[i]) c[i] = int'($signed(16'($urandom)));
            end
            [50:64]: begin
               foreach (c[i]) c[i] = $urandom_range(0, 10) - 5;
            end
            [65:74]: begin
               foreach (c[i]) c[i] = ($urandom_range(0, 1) == 0) ? 0
                                     : int'($signed(16'($urandom)));
            end
            [75:84]: begin
               // Nearly along one axis: results sit close to saturation.
               foreach (c[i]) c[i] = $urandom_range(0, 6) - 3;
               c[$urandom_range(0, 2)] = ($urandom_range(0, 1) == 0)
                  ? $urandom_range(30000, 32767) : -int'($urandom_range(30000, 32768));
            end
            [85:91]: begin
               foreach (c[i]) c[i] = corner[$urandom_range(0, 5)];
            end
            default: begin
               // Scaled copies of a small vector give the same unit vector.
               k = $urandom_range(1, 4096);
               foreach (c[i]) c[i] = ($urandom_range(0, 14) - 7) * k;
            end
         endcase
         push_vector(c[0], c[1], c[2]);
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      int drain;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_zero_vector();
      test_axis_extremes();
      test_mixed_extremes();
      test_random_vectors();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (unit_vectors_due.size() != 0) @(posedge clock);
      drain = DRAIN_CYCLES;
      repeat (drain) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
